/* design/haptic_pulse_pattern_player_macros.svh */
// Assertion macros for the haptic pulse pattern player.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef HAPTIC_PULSE_PATTERN_PLAYER_MACROS_SVH
`define HAPTIC_PULSE_PATTERN_PLAYER_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define HPP_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("hpp: invariant violated");

// Antecedent at one edge forces the consequent at the next edge.
`define HPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hpp: sequence check failed");

`endif

/* design/hpp_pkg.sv */
// Package for the haptic pulse pattern player: payload structs, register
// indexes, item kinds and pattern limits. No dependencies.
`timescale 1ns / 1ps

package hpp_pkg;

  localparam int unsigned MAX_ENTRIES = 4;
  localparam int unsigned IDX_W       = 2;   // entry index bits for MAX_ENTRIES
  localparam int unsigned CNT_W       = 3;   // entries_in_use field width
  localparam int unsigned ELAPSED_W   = 20;
  localparam int unsigned CYCLE_W     = 9;
  localparam int unsigned TPU_W       = 10;
  localparam int unsigned WORD_W      = 24;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [TPU_W-1:0]     TPU_RESET   = 10'd100;

  // Item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_USE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_UNIT  = 3'd5;

  typedef struct packed {
    logic       kind;
    logic [7:0] cycle_count;
  } hpp_in_t;

  typedef struct packed {
    logic [7:0] drive_level;
    logic       busy_res;
    logic       finished;
  } hpp_out_t;

endpackage

/* design/haptic_pulse_pattern_player.sv */
// Haptic pulse pattern player: each input transfer loads the result
// register; throughput one item per cycle while not stalled, set by the
// state update (entry select, two 8x10 unit products, two 20-bit compares).
// Input stalls only while the result register is full and stalled.
// Synchronous active-high reset clears playback state and sets the registers
// to their defaults (entries_in_use 1, ticks_per_unit 100, entries zero).
// Depends on hpp_pkg and haptic_pulse_pattern_player_macros.svh.
`timescale 1ns / 1ps
`include "haptic_pulse_pattern_player_macros.svh"

module haptic_pulse_pattern_player
  import hpp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // item input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  hpp_in_t              in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output hpp_out_t             out_data,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] entry_word [MAX_ENTRIES];
  logic [CNT_W-1:0]  entries_in_use;
  logic [TPU_W-1:0]  ticks_per_unit;

  // Writes are always taken; indexes past the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        entry_word[i] <= '0;
      end
      entries_in_use <= CNT_W'(1);
      ticks_per_unit <= TPU_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENTRY_0:     entry_word[0]  <= cfg_data;
        REG_ENTRY_1:     entry_word[1]  <= cfg_data;
        REG_ENTRY_2:     entry_word[2]  <= cfg_data;
        REG_ENTRY_3:     entry_word[3]  <= cfg_data;
        REG_ENTRIES_USE: entries_in_use <= cfg_data[CNT_W-1:0];
        REG_TICKS_UNIT:  ticks_per_unit <= cfg_data[TPU_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Playback state
  // ---------------------------------------------------------------------------
  logic                 playing,       playing_next;
  logic [7:0]           target_cycles, target_cycles_next;
  logic [CYCLE_W-1:0]   current_cycle, current_cycle_next;
  logic [IDX_W-1:0]     entry_index,   entry_index_next;
  logic [ELAPSED_W-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [7:0]           drive_now,     drive_now_next;
  logic                 done;

  logic in_xfer;
  logic out_xfer;

  // Hold the input whenever the result register is occupied and stalled.
  assign in_stall = out_valid && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // Pattern arithmetic for the current entry
  logic [CNT_W-1:0]     n_active;
  logic [IDX_W-1:0]     idx;
  logic [WORD_W-1:0]    word;
  logic [7:0]           dur, pause, inten, pause_eff;
  logic                 last_entry;
  logic [17:0]          on_len, off_len;
  logic [18:0]          total;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [CNT_W-1:0]     idx_plus;

  always_comb begin
    // Clamp the entry count into 1..MAX_ENTRIES.
    if (entries_in_use == '0) begin
      n_active = CNT_W'(1);
    end else if (entries_in_use > CNT_W'(MAX_ENTRIES)) begin
      n_active = CNT_W'(MAX_ENTRIES);
    end else begin
      n_active = entries_in_use;
    end

    // Fall back to the first entry if the count shrank under the index.
    idx      = ({1'b0, entry_index} >= n_active) ? '0 : entry_index;
    idx_plus = {1'b0, idx} + CNT_W'(1);
    word     = entry_word[idx];
    dur      = word[7:0];
    pause    = word[15:8];
    inten    = word[23:16];

    // Skip the trailing pause of the final entry in the final cycle.
    last_entry = (current_cycle == {1'b0, target_cycles}) && (idx_plus == n_active);
    pause_eff  = last_entry ? 8'd0 : pause;

    on_len  = dur * ticks_per_unit;
    off_len = pause_eff * ticks_per_unit;
    total   = {1'b0, on_len} + {1'b0, off_len};

    elapsed_inc = (elapsed_ticks == ELAPSED_MAX) ? elapsed_ticks
                                                 : elapsed_ticks + ELAPSED_W'(1);
  end

  always_comb begin
    playing_next       = playing;
    target_cycles_next = target_cycles;
    current_cycle_next = current_cycle;
    entry_index_next   = entry_index;
    elapsed_ticks_next = elapsed_ticks;
    drive_now_next     = drive_now;
    done               = 1'b0;

    if (in_data.kind == KIND_START) begin
      // Start from idle restarts the pattern; while busy only retarget.
      if (!playing) begin
        playing_next       = 1'b1;
        current_cycle_next = CYCLE_W'(1);
        entry_index_next   = '0;
        elapsed_ticks_next = '0;
      end
      target_cycles_next = in_data.cycle_count;
    end else if (playing) begin
      if (current_cycle > {1'b0, target_cycles}) begin
        // Repeat count passed: stop and pulse finished, drive left as is.
        playing_next       = 1'b0;
        current_cycle_next = CYCLE_W'(1);
        done               = 1'b1;
      end else if (elapsed_inc < {1'b0, total}) begin
        entry_index_next   = idx;
        elapsed_ticks_next = elapsed_inc;
        drive_now_next     = (elapsed_inc < {2'b00, on_len}) ? inten : 8'd0;
      end else begin
        // Entry complete: drop drive and advance, wrapping into a new cycle.
        drive_now_next     = 8'd0;
        elapsed_ticks_next = '0;
        if (idx_plus >= n_active) begin
          entry_index_next   = '0;
          current_cycle_next = current_cycle + CYCLE_W'(1);
        end else begin
          entry_index_next   = idx_plus[IDX_W-1:0];
        end
      end
    end
  end

  // Advance state only on an input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      playing       <= 1'b0;
      target_cycles <= '0;
      current_cycle <= CYCLE_W'(1);
      entry_index   <= '0;
      elapsed_ticks <= '0;
      drive_now     <= '0;
    end else if (in_xfer) begin
      playing       <= playing_next;
      target_cycles <= target_cycles_next;
      current_cycle <= current_cycle_next;
      entry_index   <= entry_index_next;
      elapsed_ticks <= elapsed_ticks_next;
      drive_now     <= drive_now_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data.drive_level <= drive_now_next;
      out_data.busy_res    <= playing_next;
      out_data.finished    <= done;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `HPP_ASSERT_ALWAYS(a_finished_not_busy, !(out_valid && out_data.finished && out_data.busy_res))
  `HPP_ASSERT_ALWAYS(a_idle_cycle_one, playing || (current_cycle == CYCLE_W'(1)))
  `HPP_ASSERT_NEXT(a_start_plays, in_xfer && (in_data.kind == KIND_START), playing && out_data.busy_res)
  `HPP_ASSERT_NEXT(a_xfer_fills_result, in_xfer, out_valid)

endmodule
